/* rtl/core/vpd_keyword_locator_core_macros.svh */
// Assertion macros for the keyword locator checker.
// No dependencies; included by the checker file only.
`ifndef VPD_KEYWORD_LOCATOR_CORE_MACROS_SVH
`define VPD_KEYWORD_LOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define VPDKL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define VPDKL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/vpdkl_pkg.sv */
// Package for the VPD keyword locator: parse phases, status codes, result word.
// No dependencies.
`timescale 1ns / 1ps

package vpdkl_pkg;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_LEN0  = 4'd1,
        PH_LEN1  = 4'd2,
        PH_HDR   = 4'd3,
        PH_NAME0 = 4'd4,
        PH_NAME1 = 4'd5,
        PH_SIZE0 = 4'd6,
        PH_SIZE1 = 4'd7,
        PH_DATA  = 4'd8
    } t_phase;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_NO_MEMD   = 2'd2
    } t_status;

    typedef struct packed {
        logic        valid;
        t_status     status;
        logic [15:0] data_offset;
        logic [15:0] data_size;
    } t_result;

    localparam logic [7:0]  CH_HASH        = 8'h23;
    localparam logic [7:0]  CH_P           = 8'h50;
    localparam logic [7:0]  CH_F           = 8'h46;
    localparam logic [15:0] MEMD_FIRST_OFF = 16'd5;
    localparam logic [15:0] MEMD_LAST_OFF  = 16'd8;
    localparam logic [15:0] FIRST_KW_OFF   = 16'd9;

    // record name character for (offset - 5) mod 4
    function automatic logic [7:0] memd_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h4D;
            2'd1:    ch = 8'h45;
            2'd2:    ch = 8'h4D;
            default: ch = 8'h44;
        endcase
        return ch;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

/* rtl/core/vpdkl_if.sv */
// Valid/ready channel interfaces for VPD bytes in and verdict words out.
// No dependencies.
`timescale 1ns / 1ps

interface vpdkl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       blob_start;
    logic       blob_end;

    modport source (output valid, data_byte, blob_start, blob_end, input ready);
    modport sink   (input valid, data_byte, blob_start, blob_end, output ready);
endinterface

interface vpdkl_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] data_offset;
    logic [15:0] data_size;

    modport source (output valid, status, data_offset, data_size, input ready);
    modport sink   (input valid, status, data_offset, data_size, output ready);
endinterface

/* rtl/core/vpd_keyword_locator_core.sv */
// Top level of the VPD keyword locator: keyword register, parser, result register.
// Depends on vpdkl_pkg, vpdkl_if, vpdkl_parser and vpdkl_out_reg.
`timescale 1ns / 1ps

// Usage:
//   i_in carries one record byte per word with blob_start and blob_end flags.
//   A word with blob_start opens a new record at offset 0 and restarts the
//   parse from any phase; bytes outside a record are dropped.
//   o_out carries at most one verdict word per record: status found (with
//   data offset and size), not found, or record name missing.
//   i_cfg_we/i_cfg_data write the sought two-character keyword; write only
//   while the block is idle.
//   Throughput: one byte per cycle while i_in.ready is high; the parse phase
//   and compares sit between the parser state and result registers.
//   Output: a verdict appears on o_out in the cycle after its deciding byte.
//   Stall: while a verdict waits unclaimed, i_in.ready stays low; it is high
//   whenever the result register is empty or being emptied.
//   Reset: the parse returns to idle, the keyword clears to zero and any
//   pending verdict is dropped.

module vpd_keyword_locator_core import vpdkl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    vpdkl_in_if.sink    i_in,
    vpdkl_out_if.source o_out
);

    logic [15:0] r_target_keyword;
    logic        space;
    logic        accept;
    t_result     result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_keyword <= '0;
        end else if (i_cfg_we) begin
            r_target_keyword <= i_cfg_data;
        end
    end

    assign i_in.ready = space;
    assign accept     = i_in.valid && space;

    vpdkl_parser u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_data_byte      (i_in.data_byte),
        .i_blob_start     (i_in.blob_start),
        .i_blob_end       (i_in.blob_end),
        .i_target_keyword (r_target_keyword),
        .o_result         (result)
    );

    vpdkl_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept && result.valid),
        .i_result (result),
        .o_space  (space),
        .o_out    (o_out)
    );

endmodule

/* rtl/core/vpdkl_parser.sv */
// Record parser: phase machine and keyword compare, one byte per accepted word.
// Depends on vpdkl_pkg.
`timescale 1ns / 1ps

module vpdkl_parser import vpdkl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    input  logic        i_blob_start,
    input  logic        i_blob_end,
    input  logic [15:0] i_target_keyword,
    output t_result     o_result
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_byte_offset, n_byte_offset;
    logic [15:0] r_record_length, n_record_length;
    logic [15:0] r_keyword_length, n_keyword_length;
    logic [15:0] r_skip_left, n_skip_left;
    logic [7:0]  r_first_name_char, n_first_name_char;
    logic        r_wide_size, n_wide_size;
    logic        r_name_hit, n_name_hit;

    t_phase      cur_phase;
    logic [15:0] cur_offset;
    logic [15:0] cur_record_length;
    logic [15:0] cur_keyword_length;
    logic [15:0] cur_skip_left;
    logic [7:0]  cur_first_name_char;
    logic        cur_wide_size;
    logic        cur_name_hit;

    logic [15:0] kw_length_full;
    logic        size_done;
    logic [16:0] next_kw_off;
    logic [15:0] skip_dec;
    logic        memd_mismatch;
    t_result     result;

    // a start byte restarts the parse from a cleared state
    assign cur_phase           = i_blob_start ? PH_LEN0 : r_phase;
    assign cur_offset          = i_blob_start ? '0 : r_byte_offset;
    assign cur_record_length   = i_blob_start ? '0 : r_record_length;
    assign cur_keyword_length  = i_blob_start ? '0 : r_keyword_length;
    assign cur_skip_left       = i_blob_start ? '0 : r_skip_left;
    assign cur_first_name_char = i_blob_start ? '0 : r_first_name_char;
    assign cur_wide_size       = i_blob_start ? 1'b0 : r_wide_size;
    assign cur_name_hit        = i_blob_start ? 1'b0 : r_name_hit;

    assign kw_length_full = (cur_phase == PH_SIZE1) ? {i_data_byte, cur_keyword_length[7:0]}
                                                    : {8'h00, i_data_byte};
    assign size_done   = ((cur_phase == PH_SIZE0) && !cur_wide_size) || (cur_phase == PH_SIZE1);
    assign next_kw_off = {1'b0, cur_offset} + 17'd1 + {1'b0, kw_length_full};
    assign skip_dec    = (cur_skip_left != 16'd0) ? cur_skip_left - 16'd1 : cur_skip_left;
    assign memd_mismatch = (i_data_byte != memd_char(cur_offset[1:0] + 2'd3));

    // verdict
    always_comb begin
        result = '{valid: 1'b0, status: ST_NOT_FOUND, data_offset: '0, data_size: '0};
        case (cur_phase)
            PH_HDR: begin
                if (cur_offset >= MEMD_FIRST_OFF) begin
                    if (memd_mismatch) begin
                        result.valid  = 1'b1;
                        result.status = ST_NO_MEMD;
                    end else if (cur_offset >= MEMD_LAST_OFF &&
                                 cur_record_length <= FIRST_KW_OFF) begin
                        result.valid  = 1'b1;
                    end
                end
            end
            PH_NAME1: begin
                if (cur_first_name_char == CH_P && i_data_byte == CH_F) begin
                    result.valid = 1'b1;
                end
            end
            PH_SIZE0, PH_SIZE1: begin
                if (size_done) begin
                    if (cur_name_hit) begin
                        result.valid       = 1'b1;
                        result.status      = ST_FOUND;
                        result.data_offset = sat_inc(cur_offset);
                        result.data_size   = kw_length_full;
                    end else if (next_kw_off >= {1'b0, cur_record_length}) begin
                        result.valid = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        if (!result.valid && i_blob_end && cur_phase != PH_IDLE) begin
            result.valid  = 1'b1;
            result.status = ST_NOT_FOUND;
        end
    end

    // next state
    always_comb begin
        n_phase           = cur_phase;
        n_byte_offset     = sat_inc(cur_offset);
        n_record_length   = cur_record_length;
        n_keyword_length  = cur_keyword_length;
        n_skip_left       = cur_skip_left;
        n_first_name_char = cur_first_name_char;
        n_wide_size       = cur_wide_size;
        n_name_hit        = cur_name_hit;
        case (cur_phase)
            PH_IDLE: begin
                n_byte_offset = cur_offset;
            end
            PH_LEN0: begin
                n_record_length = {8'h00, i_data_byte};
                n_phase         = PH_LEN1;
            end
            PH_LEN1: begin
                n_record_length = {i_data_byte, cur_record_length[7:0]};
                n_phase         = PH_HDR;
            end
            PH_HDR: begin
                if (cur_offset >= MEMD_LAST_OFF) begin
                    n_phase = PH_NAME0;
                end
            end
            PH_NAME0: begin
                n_first_name_char = i_data_byte;
                n_wide_size       = (i_data_byte == CH_HASH);
                n_phase           = PH_NAME1;
            end
            PH_NAME1: begin
                n_name_hit = ({cur_first_name_char, i_data_byte} == i_target_keyword);
                n_phase    = PH_SIZE0;
            end
            PH_SIZE0, PH_SIZE1: begin
                n_keyword_length = kw_length_full;
                if (!size_done) begin
                    n_phase = PH_SIZE1;
                end else if (kw_length_full == 16'd0) begin
                    n_phase = PH_NAME0;
                end else begin
                    n_skip_left = kw_length_full;
                    n_phase     = PH_DATA;
                end
            end
            PH_DATA: begin
                n_skip_left = skip_dec;
                if (skip_dec == 16'd0) begin
                    n_phase = PH_NAME0;
                end
            end
            default: begin
                n_phase       = PH_IDLE;
                n_byte_offset = cur_offset;
            end
        endcase
        if (result.valid) begin
            n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_IDLE;
            r_byte_offset     <= '0;
            r_record_length   <= '0;
            r_keyword_length  <= '0;
            r_skip_left       <= '0;
            r_first_name_char <= '0;
            r_wide_size       <= 1'b0;
            r_name_hit        <= 1'b0;
        end else if (i_accept) begin
            r_phase           <= n_phase;
            r_byte_offset     <= n_byte_offset;
            r_record_length   <= n_record_length;
            r_keyword_length  <= n_keyword_length;
            r_skip_left       <= n_skip_left;
            r_first_name_char <= n_first_name_char;
            r_wide_size       <= n_wide_size;
            r_name_hit        <= n_name_hit;
        end
    end

    assign o_result = result;

endmodule

/* rtl/core/vpdkl_out_reg.sv */
// Result register: holds one verdict word until the receiver takes it.
// Depends on vpdkl_pkg and vpdkl_out_if.
`timescale 1ns / 1ps

module vpdkl_out_reg import vpdkl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  t_result            i_result,
    output logic               o_space,
    vpdkl_out_if.source        o_out
);

    logic        r_valid;
    t_status     r_status;
    logic [15:0] r_data_offset;
    logic [15:0] r_data_size;

    assign o_space = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_status      <= i_result.status;
            r_data_offset <= i_result.data_offset;
            r_data_size   <= i_result.data_size;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.status      = r_status;
    assign o_out.data_offset = r_data_offset;
    assign o_out.data_size   = r_data_size;

endmodule

/* rtl/core/vpdkl_checker.sv */
// Port-level checker for the keyword locator, bound to the top level.
// Depends on vpdkl_pkg, vpd_keyword_locator_core_macros.svh and vpd_keyword_locator_core.
`timescale 1ns / 1ps
`include "vpd_keyword_locator_core_macros.svh"

module vpdkl_checker import vpdkl_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_out_status,
    input logic [15:0] i_out_data_offset,
    input logic [15:0] i_out_data_size
);

    `VPDKL_ASSERT_NOW(a_status_code, i_clk, i_rst_n, i_out_valid,
        i_out_status <= ST_NO_MEMD, "status code out of range")
    `VPDKL_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, i_out_valid && i_out_status != ST_FOUND,
        i_out_data_offset == 16'd0 && i_out_data_size == 16'd0,
        "miss word carries offset or size")
    `VPDKL_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid || i_out_ready,
        i_in_ready, "input held off with free result register")
    `VPDKL_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_status) && $stable(i_out_data_offset) &&
        $stable(i_out_data_size), "stalled verdict word changed")

endmodule

bind vpd_keyword_locator_core vpdkl_checker u_vpdkl_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_status      (o_out.status),
    .i_out_data_offset (o_out.data_offset),
    .i_out_data_size   (o_out.data_size)
);

/* dv/vpdkl_locator_checker.sv */
// Checker for the VPD keyword locator: watches the byte and verdict channels,
// predicts each verdict word and compares it field by field.
// Depends on vpdkl_pkg and vpdkl_if.
`timescale 1ns / 1ps

module vpdkl_locator_checker import vpdkl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    vpdkl_in_if         i_in_mon,
    vpdkl_out_if        i_out_mon,
    output int          o_errors,
    output int          o_pending,
    output int          o_found,
    output int          o_missing,
    output int          o_bad_name,
    output int          o_stalls
);

    localparam logic [7:0] REC_NAME [4] = '{8'h4D, 8'h45, 8'h4D, 8'h44};

    typedef struct packed {
        t_status     status;
        logic [15:0] data_offset;
        logic [15:0] data_size;
    } t_verdict_word;

    t_verdict_word verdict_q[$];
    t_verdict_word head;

    logic [15:0] sought_kw;
    t_phase      phase;
    logic [15:0] rec_offset;
    logic [15:0] rec_len;
    logic [15:0] kw_len;
    logic [15:0] skip_cnt;
    logic [7:0]  name_hi;
    logic        wide_size;
    logic        name_match;

    int err_cnt      = 0;
    int found_cnt    = 0;
    int missing_cnt  = 0;
    int bad_name_cnt = 0;
    int stall_cnt    = 0;

    task automatic clear_parse();
        phase      = PH_IDLE;
        rec_offset = '0;
        rec_len    = '0;
        kw_len     = '0;
        skip_cnt   = '0;
        name_hi    = '0;
        wide_size  = 1'b0;
        name_match = 1'b0;
    endtask

    task automatic parse_byte(input logic [7:0] d, input logic s, input logic e);
        logic [15:0] cur;
        logic [15:0] memd_pos;
        logic [16:0] next_start;
        logic        size_done;
        logic        decided;
        t_status     st;
        logic [15:0] r_off;
        logic [15:0] r_size;
        size_done = 1'b0;
        decided   = 1'b0;
        st        = ST_NOT_FOUND;
        r_off     = '0;
        r_size    = '0;
        if (s) begin
            clear_parse();
            phase = PH_LEN0;
        end
        if (phase == PH_IDLE)
            return;
        cur = rec_offset;
        case (phase)
            PH_LEN0: begin
                rec_len = {8'h00, d};
                phase   = PH_LEN1;
            end
            PH_LEN1: begin
                rec_len[15:8] = d;
                phase         = PH_HDR;
            end
            PH_HDR: begin
                if (cur >= MEMD_FIRST_OFF) begin
                    memd_pos = cur - MEMD_FIRST_OFF;
                    if (d != REC_NAME[memd_pos[1:0]]) begin
                        decided = 1'b1;
                        st      = ST_NO_MEMD;
                    end else if (cur >= MEMD_LAST_OFF) begin
                        if (FIRST_KW_OFF >= rec_len)
                            decided = 1'b1;
                        else
                            phase = PH_NAME0;
                    end
                end
            end
            PH_NAME0: begin
                name_hi   = d;
                wide_size = (d == CH_HASH);
                phase     = PH_NAME1;
            end
            PH_NAME1: begin
                if (name_hi == CH_P && d == CH_F) begin
                    decided = 1'b1;
                end else begin
                    name_match = ({name_hi, d} == sought_kw);
                    phase      = PH_SIZE0;
                end
            end
            PH_SIZE0: begin
                kw_len = {8'h00, d};
                if (wide_size)
                    phase = PH_SIZE1;
                else
                    size_done = 1'b1;
            end
            PH_SIZE1: begin
                kw_len[15:8] = d;
                size_done    = 1'b1;
            end
            PH_DATA: begin
                if (skip_cnt != 0)
                    skip_cnt = skip_cnt - 16'd1;
                if (skip_cnt == 0)
                    phase = PH_NAME0;
            end
            default: begin
                phase = PH_IDLE;
                return;
            end
        endcase

        if (size_done) begin
            if (name_match) begin
                decided = 1'b1;
                st      = ST_FOUND;
                r_off   = (cur == 16'hFFFF) ? cur : cur + 16'd1;
                r_size  = kw_len;
            end else begin
                next_start = {1'b0, cur} + 17'd1 + {1'b0, kw_len};
                if (next_start >= {1'b0, rec_len}) begin
                    decided = 1'b1;
                end else if (kw_len == 0) begin
                    phase = PH_NAME0;
                end else begin
                    skip_cnt = kw_len;
                    phase    = PH_DATA;
                end
            end
        end

        if (rec_offset != 16'hFFFF)
            rec_offset = rec_offset + 16'd1;
        if (!decided && e)
            decided = 1'b1;
        if (decided) begin
            phase = PH_IDLE;
            verdict_q.push_back('{st, r_off, r_size});
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sought_kw = '0;
            clear_parse();
            verdict_q.delete();
        end else begin
            if (i_cfg_we)
                sought_kw = i_cfg_data;
            if (i_in_mon.valid && !i_in_mon.ready)
                stall_cnt++;
            if (i_in_mon.valid && i_in_mon.ready)
                parse_byte(i_in_mon.data_byte, i_in_mon.blob_start, i_in_mon.blob_end);
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (verdict_q.size() == 0) begin
                    err_cnt++;
                    $error("verdict word with none expected: status %0d offset %0d size %0d",
                           i_out_mon.status, i_out_mon.data_offset, i_out_mon.data_size);
                end else begin
                    head = verdict_q.pop_front();
                    if (i_out_mon.status != head.status) begin
                        err_cnt++;
                        $error("status mismatch: expected %0d, actual %0d",
                               head.status, i_out_mon.status);
                    end
                    if (i_out_mon.data_offset != head.data_offset) begin
                        err_cnt++;
                        $error("data_offset mismatch: expected %0d, actual %0d",
                               head.data_offset, i_out_mon.data_offset);
                    end
                    if (i_out_mon.data_size != head.data_size) begin
                        err_cnt++;
                        $error("data_size mismatch: expected %0d, actual %0d",
                               head.data_size, i_out_mon.data_size);
                    end
                    case (head.status)
                        ST_FOUND:     found_cnt++;
                        ST_NOT_FOUND: missing_cnt++;
                        default:      bad_name_cnt++;
                    endcase
                end
            end
        end
        o_errors   <= err_cnt;
        o_pending  <= verdict_q.size();
        o_found    <= found_cnt;
        o_missing  <= missing_cnt;
        o_bad_name <= bad_name_cnt;
        o_stalls   <= stall_cnt;
    end

endmodule

/* dv/tb.sv */
// Testbench top for the VPD keyword locator: clock, reset, byte stimulus,
// result back-pressure and the final verdict. Depends on vpdkl_pkg, vpdkl_if,
// vpd_keyword_locator_core and vpdkl_locator_checker.
`timescale 1ns / 1ps

module tb import vpdkl_pkg::*; ();

    localparam logic [15:0] KW_VD     = "VD";
    localparam logic [15:0] KW_AB     = "AB";
    localparam int          LONG_HOLD = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;

    vpdkl_in_if  in_ch ();
    vpdkl_out_if out_ch ();

    int errors;
    int pending;
    int n_found;
    int n_missing;
    int n_bad_name;
    int n_stalls;

    logic [7:0]  blob_q[$];
    logic [15:0] target_kw;
    logic        quiet;
    logic        hold_req;
    logic        hold_done;
    logic        held;
    int          record_bytes;
    int          blobs;
    int          guard;

    vpd_keyword_locator_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    vpdkl_locator_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in_mon   (in_ch),
        .i_out_mon  (out_ch),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_found    (n_found),
        .o_missing  (n_missing),
        .o_bad_name (n_bad_name),
        .o_stalls   (n_stalls)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #15ms;
        $display("run timed out");
        $display("DONE: errors detected");
        $finish;
    end

    // result side: random stalls, one long hold on request
    initial begin
        out_ch.ready = 1'b0;
        hold_done    = 1'b0;
        forever begin
            if (hold_req && !hold_done) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    function automatic logic [7:0] ascii();
        return 8'($urandom_range(65, 90));
    endfunction

    function automatic logic [15:0] pick_target();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return {CH_HASH, ascii()};
            3:       return {CH_P, CH_F};
            4:       return 16'($urandom);
            default: return {ascii(), ascii()};
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic s, input logic e);
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= d;
        in_ch.blob_start <= s;
        in_ch.blob_end   <= e;
        do @(posedge i_clk); while (!in_ch.ready);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    task automatic send_blob(input int n, input logic with_end);
        for (int i = 0; i < n; i++)
            send_byte(blob_q[i], i == 0, with_end && (i == n - 1));
        record_bytes += n;
    endtask

    // force a verdict, then drain every expected word
    task automatic settle();
        send_byte(8'($urandom), 1'b1, 1'b1);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_target(input logic [15:0] v);
        cfg_data  <= v;
        cfg_we    <= 1'b1;
        target_kw = v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic start_record(input logic [7:0] rt_len);
        blob_q.delete();
        blob_q.push_back(8'h00);
        blob_q.push_back(8'h00);
        blob_q.push_back(8'h52);
        blob_q.push_back(8'h54);
        blob_q.push_back(rt_len);
        blob_q.push_back(8'h4D);
        blob_q.push_back(8'h45);
        blob_q.push_back(8'h4D);
        blob_q.push_back(8'h44);
    endtask

    task automatic add_keyword(input logic [15:0] name, input logic [15:0] size);
        blob_q.push_back(name[15:8]);
        blob_q.push_back(name[7:0]);
        blob_q.push_back(size[7:0]);
        if (name[15:8] == CH_HASH)
            blob_q.push_back(size[15:8]);
        repeat (size) blob_q.push_back(8'($urandom));
    endtask

    task automatic set_length(input logic [15:0] len);
        blob_q[0] = len[7:0];
        blob_q[1] = len[15:8];
    endtask

    task automatic make_record();
        logic [15:0] name;
        logic [15:0] rlen;
        int          sz;
        start_record(8'($urandom));
        repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3, 4, 5: name = target_kw;
                6, 7, 8:          name = {CH_HASH, 8'($urandom)};
                9:                name = {CH_P, CH_F};
                10, 11, 12, 13:   name = {ascii(), ascii()};
                default:          name = 16'($urandom);
            endcase
            if (name[15:8] == CH_HASH && $urandom_range(0, 7) == 0)
                sz = $urandom_range(256, 300);
            else if ($urandom_range(0, 15) == 0)
                sz = $urandom_range(7, 40);
            else
                sz = $urandom_range(0, 6);
            add_keyword(name, 16'(sz));
        end
        rlen = 16'(blob_q.size());
        case ($urandom_range(0, 9))
            7:       rlen = 16'($urandom_range(0, blob_q.size()));
            8:       rlen = rlen + 16'($urandom_range(1, 3));
            9:       rlen = 16'hFFFF;
            default: ;
        endcase
        set_length(rlen);
        if ($urandom_range(0, 9) == 0)
            blob_q[5 + $urandom_range(0, 3)] ^= (8'h01 << $urandom_range(0, 7));
    endtask

    initial begin
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = '0;
        in_ch.blob_start = 1'b0;
        in_ch.blob_end   = 1'b0;
        target_kw        = '0;
        quiet            = 1'b0;
        hold_req         = 1'b0;
        held             = 1'b0;
        record_bytes     = 0;
        blobs            = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // stray bytes while idle, then a one-byte blob
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hA5, 1'b1, 1'b1);

        settle();
        write_target(16'h0000);
        start_record(8'h00);
        add_keyword(KW_AB, 16'd2);
        add_keyword(16'h0000, 16'd3);
        set_length(16'(blob_q.size()));
        send_blob(blob_q.size(), 1'b1);

        // record name wrong on its first and on its last character
        start_record(8'hFF);
        add_keyword(KW_AB, 16'd1);
        set_length(16'(blob_q.size()));
        blob_q[5] = 8'h00;
        send_blob(blob_q.size(), 1'b1);
        start_record(8'h00);
        set_length(16'(blob_q.size()));
        blob_q[8] = 8'hFF;
        send_blob(blob_q.size(), 1'b1);

        // record length too short for any keyword
        start_record(8'h00);
        add_keyword(KW_AB, 16'd1);
        set_length(16'd9);
        send_blob(blob_q.size(), 1'b1);
        start_record(8'h00);
        set_length(16'h0000);
        send_blob(blob_q.size(), 1'b0);

        // padding keyword ends the walk even when sought
        settle();
        write_target({CH_P, CH_F});
        start_record(8'h00);
        add_keyword(KW_AB, 16'd1);
        add_keyword({CH_P, CH_F}, 16'd2);
        set_length(16'(blob_q.size()));
        send_blob(blob_q.size(), 1'b1);

        settle();
        write_target(16'hFFFF);
        start_record(8'hFF);
        add_keyword(KW_AB, 16'd0);
        add_keyword({CH_HASH, 8'h5A}, 16'h0102);
        add_keyword(16'hFFFF, 16'd5);
        set_length(16'(blob_q.size()));
        send_blob(blob_q.size(), 1'b1);

        // record limit reached on the size byte of the keyword before the hit
        settle();
        write_target(KW_VD);
        start_record(8'h00);
        add_keyword(KW_AB, 16'd4);
        add_keyword(KW_VD, 16'd1);
        set_length(16'd16);
        send_blob(blob_q.size(), 1'b1);

        // restart mid-record
        start_record(8'h00);
        add_keyword(KW_AB, 16'd3);
        set_length(16'(blob_q.size()));
        send_blob(7, 1'b0);
        start_record(8'h00);
        add_keyword(KW_VD, 16'd2);
        set_length(16'(blob_q.size()));
        send_blob(blob_q.size(), 1'b1);

        // blob ends inside keyword data
        start_record(8'h00);
        add_keyword({CH_HASH, 8'h51}, 16'd300);
        set_length(16'(blob_q.size()));
        send_blob(16, 1'b1);
        record_bytes = 0;

        while (record_bytes < 230) begin
            if (record_bytes >= 190)
                quiet = 1'b1;
            if (!held && record_bytes >= 40) begin
                // hold the result side while one-byte blobs keep coming
                settle();
                hold_req = 1'b1;
                repeat (12) send_byte(8'($urandom), 1'b1, 1'b1);
                settle();
                held = 1'b1;
            end
            if (blobs % 8 == 7) begin
                settle();
                write_target(pick_target());
            end
            case ($urandom_range(0, 9))
                0: begin
                    repeat ($urandom_range(1, 3))
                        send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
                end
                1: begin
                    blob_q.delete();
                    repeat ($urandom_range(1, 20)) blob_q.push_back(8'($urandom));
                    send_blob(blob_q.size(), 1'($urandom_range(0, 1)));
                end
                default: begin
                    make_record();
                    case ($urandom_range(0, 9))
                        7, 8:    send_blob($urandom_range(1, blob_q.size()), 1'b1);
                        9:       send_blob(blob_q.size(), 1'b0);
                        default: send_blob(blob_q.size(), 1'b1);
                    endcase
                end
            endcase
            blobs++;
        end

        in_ch.valid <= 1'b0;
        guard = 0;
        @(posedge i_clk);
        while (pending != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        if (pending != 0)
            $error("verdict words still expected at the end: %0d", pending);

        $display("Covered %0d blobs and %0d random record bytes after the directed cases.",
                 blobs, record_bytes);
        $display("Verdicts: %0d found, %0d not found, %0d bad record name; %0d input stall cycles.",
                 n_found, n_missing, n_bad_name, n_stalls);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/vpdkl_pkg.sv
rtl/core/vpdkl_if.sv
rtl/core/vpdkl_parser.sv
rtl/core/vpdkl_out_reg.sv
rtl/core/vpd_keyword_locator_core.sv
rtl/core/vpdkl_checker.sv
dv/vpdkl_locator_checker.sv
dv/tb.sv
